### sv/bmhq_pkg.sv
// Shared types and constants for the binary min-heap priority queue.
`default_nettype none

package bmhq_pkg;

    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_POP_LD,
        S_DN,
        S_PUT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic up_move;
        logic pop_load;
        logic dn_move;
        logic put;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_op;
        logic empty;
        logic full;
        logic up_stop;
        logic up_next_root;
        logic dn_leaf_now;
        logic dn_stop;
        logic dn_leaf_next;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

### sv/bmhq_in_if.sv
// Input channel of the heap queue: operation and key with valid/ready.
`default_nettype none

interface bmhq_in_if import bmhq_pkg::*; ();
    logic valid;
    logic ready;
    logic op;
    t_key key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

`default_nettype wire

### sv/bmhq_out_if.sv
// Result channel of the heap queue: popped key, status and count with valid/ready.
`default_nettype none

interface bmhq_out_if import bmhq_pkg::*; ();
    logic                valid;
    logic                ready;
    t_key                popped_key;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output popped_key, output status, output count,
                    input ready);
    modport sink   (input valid, input popped_key, input status, input count,
                    output ready);
endinterface

`default_nettype wire

### sv/bmhq_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]        o_rdata_a,
    output logic [WIDTH-1:0]        o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

### sv/bmhq_ctrl.sv
// Controller state machine that sequences pushes, pops and sifts.
`default_nettype none

module bmhq_ctrl import bmhq_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (!i_stat.in_op) begin
                        if (i_stat.full) begin
                            n_state = S_DONE;
                        end else if (i_stat.empty) begin
                            n_state = S_PUT;
                        end else begin
                            n_state = S_UP;
                        end
                    end else begin
                        n_state = i_stat.empty ? S_DONE : S_POP_LD;
                    end
                end
            end
            S_UP: begin
                if (i_stat.up_stop) begin
                    n_state = S_PUT;
                end else begin
                    // The parent moves down into the hole; the parent's parent is read.
                    o_cmd.up_move = 1'b1;
                    if (i_stat.up_next_root) begin
                        n_state = S_PUT;
                    end
                end
            end
            S_POP_LD: begin
                o_cmd.pop_load = 1'b1;
                n_state = i_stat.dn_leaf_now ? S_PUT : S_DN;
            end
            S_DN: begin
                if (i_stat.dn_stop) begin
                    n_state = S_PUT;
                end else begin
                    o_cmd.dn_move = 1'b1;
                    if (i_stat.dn_leaf_next) begin
                        n_state = S_PUT;
                    end
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/bmhq_datapath.sv
// Heap datapath: heap RAM, entry count, hole pointer, held key and result register.
`default_nettype none

module bmhq_datapath import bmhq_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  wire                  i_op,
    input  wire [KEY_W-1:0]      i_key,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [KEY_W-1:0]     o_popped_key,
    output logic [STATUS_W-1:0]  o_status,
    output logic [COUNT_W-1:0]   o_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_hole, n_hole;
    t_key               r_val, n_val;
    t_key               r_popped, n_popped;
    t_status            r_status, n_status;
    logic               r_out_valid, n_out_valid;
    t_key               r_out_popped, n_out_popped;
    t_status            r_out_status, n_out_status;
    logic [COUNT_W-1:0] r_out_count, n_out_count;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
    t_key          ram_wdata, rd_a, rd_b;

    logic [CW-1:0] count_dec;
    logic [AW-1:0] cnt_idx, cnt_par, hole_par, hole_gpar;
    logic [IW-1:0] n_ext, lc_idx, rc_idx, pick_idx, pick_lc, pick_rc;
    logic          rc_ok, pick_right, is_empty, is_full;
    t_key          child;

    bmhq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Index arithmetic for parents and children; child indices get two spare bits.
    assign count_dec  = r_count - CW'(1);
    assign cnt_idx    = r_count[AW-1:0];
    assign cnt_par    = (cnt_idx - AW'(1)) >> 1;
    assign hole_par   = (r_hole - AW'(1)) >> 1;
    assign hole_gpar  = (hole_par - AW'(1)) >> 1;
    assign n_ext      = IW'(r_count);
    assign lc_idx     = IW'({r_hole, 1'b1});
    assign rc_idx     = lc_idx + IW'(1);
    assign rc_ok      = rc_idx < n_ext;
    assign pick_right = rc_ok && (rd_b < rd_a);
    assign child      = pick_right ? rd_b : rd_a;
    assign pick_idx   = pick_right ? rc_idx : lc_idx;
    assign pick_lc    = IW'({pick_idx[AW-1:0], 1'b1});
    assign pick_rc    = pick_lc + IW'(1);
    assign is_empty   = (r_count == '0);
    assign is_full    = (r_count == CW'(CAPACITY));

    assign o_stat.in_op        = i_op;
    assign o_stat.empty        = is_empty;
    assign o_stat.full         = is_full;
    assign o_stat.up_stop      = (rd_a <= r_val);
    assign o_stat.up_next_root = (hole_par == '0);
    assign o_stat.dn_leaf_now  = (lc_idx >= n_ext);
    assign o_stat.dn_stop      = (r_val <= child);
    assign o_stat.dn_leaf_next = (pick_lc >= n_ext);
    assign o_stat.out_free     = !r_out_valid || i_out_ready;

    always_comb begin
        n_count      = r_count;
        n_hole       = r_hole;
        n_val        = r_val;
        n_popped     = r_popped;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_popped = r_out_popped;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = r_hole;
        ram_wdata    = r_val;
        ram_raddr_a  = '0;
        ram_raddr_b  = '0;

        if (i_cmd.accept) begin
            n_val    = i_key;
            n_popped = '0;
            if (!i_op) begin
                n_status = is_full ? ST_PUSH_FULL : ST_OK;
                if (!is_full) begin
                    // The new key sits in a hole at the end; its parent is read now.
                    n_hole      = cnt_idx;
                    n_count     = r_count + CW'(1);
                    ram_raddr_a = cnt_par;
                end
            end else begin
                n_status = is_empty ? ST_POP_EMPTY : ST_OK;
                if (!is_empty) begin
                    n_hole      = '0;
                    n_count     = count_dec;
                    ram_raddr_a = '0;
                    ram_raddr_b = count_dec[AW-1:0];
                end
            end
        end

        if (i_cmd.up_move) begin
            ram_we      = 1'b1;
            ram_wdata   = rd_a;
            n_hole      = hole_par;
            ram_raddr_a = hole_gpar;
        end

        if (i_cmd.pop_load) begin
            // Root is the result; the last entry becomes the key being sifted down.
            n_popped    = rd_a;
            n_val       = rd_b;
            ram_raddr_a = lc_idx[AW-1:0];
            ram_raddr_b = rc_idx[AW-1:0];
        end

        if (i_cmd.dn_move) begin
            ram_we      = 1'b1;
            ram_wdata   = child;
            n_hole      = pick_idx[AW-1:0];
            ram_raddr_a = pick_lc[AW-1:0];
            ram_raddr_b = pick_rc[AW-1:0];
        end

        if (i_cmd.put) begin
            ram_we = 1'b1;
        end

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.emit) begin
            n_out_valid  = 1'b1;
            n_out_popped = r_popped;
            n_out_status = r_status;
            n_out_count  = COUNT_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_hole       <= n_hole;
        r_val        <= n_val;
        r_popped     <= n_popped;
        r_status     <= n_status;
        r_out_popped <= n_out_popped;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign o_out_valid  = r_out_valid;
    assign o_popped_key = r_out_popped;
    assign o_status     = r_out_status;
    assign o_count      = r_out_count;

endmodule

`default_nettype wire

### sv/binary_min_heap_queue.sv
// Binary min-heap priority queue of signed 32-bit keys with push and pop transactions.
// Each input transaction either pushes its key or pops the smallest key held, and
// yields exactly one result with the popped key (zero unless a pop succeeded), a
// status (ok, pop on empty, push on full) and the entry count afterwards. Keys live
// in a RAM of CAPACITY entries; one transaction is worked on at a time. A sift moves
// one heap level per clock, paced by the registered read of the heap RAM. A rejected
// push or pop skips the sift and goes straight to its result. A result enters the
// output register only when that register is empty or its result is being taken.
// The next transaction is accepted as soon as the result has entered the output
// register, even if it has not yet been taken.
// No clearing pass is needed after reset.
`default_nettype none

module binary_min_heap_queue import bmhq_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bmhq_in_if.sink     i_in,
    bmhq_out_if.source  o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    bmhq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bmhq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_op         (i_in.op),
        .i_key        (i_in.key),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_popped_key (o_out.popped_key),
        .o_status     (o_out.status),
        .o_count      (o_out.count)
    );

endmodule

`default_nettype wire

### sv/bmhq_checker.sv
// Port-level assertions for the heap queue and the bind that attaches them.
`default_nettype none

module bmhq_checker import bmhq_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                i_in_ready,
    input wire                i_out_valid,
    input wire                i_out_ready,
    input wire [KEY_W-1:0]    i_out_popped_key,
    input wire [STATUS_W-1:0] i_out_status,
    input wire [COUNT_W-1:0]  i_out_count
);

    // A pop on an empty heap leaves the heap empty and returns no key.
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status == ST_POP_EMPTY)
            |-> (i_out_count == '0 && i_out_popped_key == '0))
        else $error("pop on empty heap reported a key or a nonzero count");

    // A push on a full heap reports the full count and no key.
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status == ST_PUSH_FULL)
            |-> (i_out_count == COUNT_W'(CAPACITY) && i_out_popped_key == '0))
        else $error("push on full heap reported a wrong count or a key");

    // One transaction at a time: the input closes right after an acceptance.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted a second transaction while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
            |=> (i_out_valid && $stable(i_out_popped_key) && $stable(i_out_status)
                 && $stable(i_out_count)))
        else $error("stalled result changed or was dropped");

endmodule

bind binary_min_heap_queue bmhq_checker #(
    .CAPACITY (CAPACITY)
) u_bmhq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_popped_key (o_out.popped_key),
    .i_out_status     (o_out.status),
    .i_out_count      (o_out.count)
);

`default_nettype wire

### bench/heap_shadow_pkg.sv
// Scoreboard class that mirrors the heap queue and checks its results in order.
package heap_shadow_pkg;
    import bmhq_pkg::*;

    localparam int HEAP_DEPTH = 64;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct {
        t_key               popped_key;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } heap_result_t;

    class heap_shadow;
        t_key         keys [HEAP_DEPTH];
        int unsigned  held;
        heap_result_t due_results[$];
        int unsigned  mismatches;
        int unsigned  n_push;
        int unsigned  n_pop;
        int unsigned  n_pop_empty;
        int unsigned  n_push_full;
        int unsigned  peak;

        function new();
            held        = 0;
            mismatches  = 0;
            n_push      = 0;
            n_pop       = 0;
            n_pop_empty = 0;
            n_push_full = 0;
            peak        = 0;
        endfunction

        // Applies one accepted transaction to the mirror and queues its result.
        function void apply_op(logic op, t_key key);
            heap_result_t r;
            int unsigned  pos;
            int unsigned  up;
            int unsigned  lc;
            int unsigned  pick;
            t_key         t;
            r.popped_key = '0;
            r.status     = ST_OK;
            if (op == OP_PUSH) begin
                n_push++;
                if (held >= HEAP_DEPTH) begin
                    r.status = ST_PUSH_FULL;
                    n_push_full++;
                end else begin
                    keys[held] = key;
                    held++;
                    pos = held - 1;
                    // Walk up while the parent is strictly larger; a tie stops.
                    while (pos > 0) begin
                        up = (pos - 1) / 2;
                        if (keys[up] <= keys[pos]) break;
                        t          = keys[up];
                        keys[up]   = keys[pos];
                        keys[pos]  = t;
                        pos        = up;
                    end
                end
            end else begin
                n_pop++;
                if (held == 0) begin
                    r.status = ST_POP_EMPTY;
                    n_pop_empty++;
                end else begin
                    r.popped_key = keys[0];
                    keys[0]      = keys[held - 1];
                    held--;
                    pos = 0;
                    // The right child wins only when strictly smaller than the left.
                    while (1'b1) begin
                        lc = pos * 2 + 1;
                        if (lc >= held) break;
                        pick = lc;
                        if (lc + 1 < held && keys[lc + 1] < keys[lc]) pick = lc + 1;
                        if (keys[pos] <= keys[pick]) break;
                        t          = keys[pos];
                        keys[pos]  = keys[pick];
                        keys[pick] = t;
                        pos        = pick;
                    end
                end
            end
            if (held > peak) peak = held;
            r.count = COUNT_W'(held);
            due_results.push_back(r);
        endfunction

        function void report_mismatch(string what);
            if (mismatches < 10) $display("heap result mismatch: %s", what);
            mismatches++;
        endfunction

        // Compares one taken result with the oldest outstanding one.
        function void check_result(t_key popped_key, logic [STATUS_W-1:0] status,
                                   logic [COUNT_W-1:0] count);
            heap_result_t e;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result key=%0d status=%0d count=%0d",
                                          popped_key, status, count));
            end else begin
                e = due_results.pop_front();
                if (popped_key !== e.popped_key || status !== e.status || count !== e.count)
                    report_mismatch($sformatf(
                        "expected key=%0d status=%0d count=%0d, got key=%0d status=%0d count=%0d",
                        e.popped_key, e.status, e.count, popped_key, status, count));
            end
        endfunction
    endclass
endpackage

### bench/tb_binary_min_heap_queue.sv
// Testbench for the binary min-heap queue: directed and random push/pop traffic with stalls.
module tb_binary_min_heap_queue;
    import bmhq_pkg::*;
    import heap_shadow_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM   = 1726;
    localparam int HOLD_AT      = 300;
    localparam int PAUSE_AT     = 900;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 500000;

    localparam t_key KEY_MAX = 32'sh7FFF_FFFF;
    localparam t_key KEY_MIN = 32'sh8000_0000;

    typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_SPARSE} sink_mode_t;

    logic        i_clk    = 1'b0;
    logic        i_rst_n;
    logic        hold_req = 1'b0;
    int unsigned burst_left = 0;
    int unsigned cycles     = 0;
    heap_shadow  shadow     = new();

    bmhq_in_if  in_ch();
    bmhq_out_if out_ch();

    binary_min_heap_queue #(.CAPACITY(HEAP_DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            shadow.check_result(out_ch.popped_key, out_ch.status, out_ch.count);
    end

    // Offers one transaction and returns once it is accepted; bursts end in random gaps.
    task automatic send_item(input logic op, input t_key key);
        int unsigned gap;
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.key   <= key;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        shadow.apply_op(op, key);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    task automatic wait_drained();
        while (shadow.due_results.size() != 0) @(posedge i_clk);
    endtask

    // Mixes extremes, a narrow band that produces many ties, and full-range keys.
    function automatic t_key pick_key();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            case ($urandom_range(0, 3))
                0: return KEY_MAX;
                1: return KEY_MIN;
                2: return '0;
                default: return -1;
            endcase
        end
        if (sel <= 3) return t_key'($urandom_range(0, 16)) - 8;
        return t_key'($urandom);
    endfunction

    initial begin : result_sink
        sink_mode_t  mode;
        int unsigned mode_left;
        int unsigned phase;
        logic        hold_done;
        mode      = SINK_OPEN;
        mode_left = 0;
        phase     = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                // Long hold-off so the block backs up and stalls its input.
                hold_done    = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(100, 400);
                end
                mode_left--;
                phase++;
                case (mode)
                    SINK_OPEN:     out_ch.ready <= 1'b1;
                    SINK_RANDOM:   out_ch.ready <= ($urandom_range(0, 9) < 6);
                    SINK_PERIODIC: out_ch.ready <= ((phase % 7) >= 3);
                    default:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int unsigned push_pct;
        int unsigned phase_left;
        logic        op;
        push_pct   = 50;
        phase_left = 0;
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.op     <= OP_PUSH;
        in_ch.key    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: pop on empty, key extremes, ties, drain past empty, ties again.
        send_item(OP_POP, '0);
        send_item(OP_PUSH, KEY_MAX);
        send_item(OP_PUSH, KEY_MIN);
        send_item(OP_PUSH, '0);
        send_item(OP_PUSH, -1);
        send_item(OP_PUSH, 1);
        send_item(OP_PUSH, '0);
        send_item(OP_PUSH, '0);
        send_item(OP_PUSH, -1);
        repeat (9) send_item(OP_POP, KEY_MAX);
        send_item(OP_PUSH, 5);
        send_item(OP_PUSH, 5);
        send_item(OP_PUSH, 5);
        send_item(OP_PUSH, 3);
        send_item(OP_POP, '0);
        send_item(OP_POP, '0);

        // Random phases lean toward filling, draining or balance to reach both ends.
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 20;
                    default: push_pct = 50;
                endcase
                phase_left = $urandom_range(40, 120);
            end
            phase_left--;
            if (i == HOLD_AT) hold_req <= 1'b1;
            if (i == PAUSE_AT) begin
                in_ch.valid <= 1'b0;
                wait_drained();
            end
            op = ($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP;
            send_item(op, pick_key());
        end

        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d pushes (%0d on a full heap) and %0d pops (%0d on an empty heap).",
                 shadow.n_push, shadow.n_push_full, shadow.n_pop, shadow.n_pop_empty);
        $display("Peak occupancy %0d of %0d entries, %0d mismatches, %0d results outstanding.",
                 shadow.peak, HEAP_DEPTH, shadow.mismatches, shadow.due_results.size());
        if (shadow.mismatches == 0 && shadow.due_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
